FILE: design/ivc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivc_pkg
// Shared widths, command codes and record types of the interval compositing
// block.
// ----------------------------------------------------------------------------
package ivc_pkg;

    // Field widths of one transaction.
    localparam int GROUP_BITS      = 16;
    localparam int DEPTH_BITS      = 24;
    localparam int GRADE_BITS      = 16;
    localparam int FRAC_BITS       = 16;
    localparam int FUNC_BITS       = 2;
    localparam int TABLE_DEPTH_DEF = 1024;

    // Packed stream widths.
    localparam int IN_DATA_BITS  = GROUP_BITS + 2 * DEPTH_BITS + GRADE_BITS;
    localparam int OUT_DATA_BITS = 40;

    // Function codes carried on the input tuser.
    localparam logic [FUNC_BITS-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_QUERY = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    // One interval record as stored in the table. The last member lands in
    // the lowest bits, so the layout matches the input tdata packing.
    typedef struct packed {
        logic [GRADE_BITS-1:0] grade;
        logic [DEPTH_BITS-1:0] depth_to;
        logic [DEPTH_BITS-1:0] depth_from;
        logic [GROUP_BITS-1:0] group_id;
    } t_rec;

    // One classified command queued between front and back.
    typedef struct packed {
        t_op  op;
        t_rec rec;
    } t_cmd;

endpackage

FILE: design/ivc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivc_front
// Accepts input transactions, decodes the function code and queues the
// resulting commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ivc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ivc_pkg::IN_DATA_BITS-1:0]    i_s_tdata,
    input  logic [ivc_pkg::FUNC_BITS-1:0]       i_s_tuser,
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_ready,
    output ivc_pkg::t_cmd                       o_cmd
);

    ivc_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    ivc_pkg::t_cmd w_cmd;
    logic          w_push, w_pop, w_known, w_acc;

    // Decode the function code; unused codes are taken and dropped.
    always_comb begin
        w_cmd.rec = ivc_pkg::t_rec'(i_s_tdata);
        w_cmd.op  = ivc_pkg::OP_LOAD;
        w_known   = 1'b1;
        unique case (i_s_tuser)
            ivc_pkg::FUNC_LOAD:  w_cmd.op = ivc_pkg::OP_LOAD;
            ivc_pkg::FUNC_QUERY: w_cmd.op = ivc_pkg::OP_QUERY;
            ivc_pkg::FUNC_CLEAR: w_cmd.op = ivc_pkg::OP_CLEAR;
            default:             w_known  = 1'b0;
        endcase
    end

    assign o_s_tready  = (r_cnt != 2'd2);
    assign w_acc       = i_s_tvalid && o_s_tready;
    assign w_push      = w_acc && w_known;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

FILE: design/ivc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivc_back
// Executes queued commands: record loads, table clears and segment queries
// with a linear table walk, a multiply-accumulate pipeline and two restoring
// dividers. Holds the result register of the output stream.
// ----------------------------------------------------------------------------
module ivc_back #(
    parameter int TABLE_DEPTH = ivc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cmd_valid,
    output logic                                o_cmd_ready,
    input  ivc_pkg::t_cmd                       i_cmd,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [ivc_pkg::OUT_DATA_BITS-1:0]   o_m_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 2);
    localparam int DB = ivc_pkg::DEPTH_BITS;
    localparam int GB = ivc_pkg::GRADE_BITS;
    localparam int FB = ivc_pkg::FRAC_BITS;
    localparam int PW = DB + GB;
    localparam int LW = DB + CW;
    localparam int SW = PW + CW;
    localparam int RW = DB + FB;
    localparam int STW = $clog2(FB);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state          r_state;
    ivc_pkg::t_rec   r_mem [TABLE_DEPTH];
    ivc_pkg::t_rec   r_rd;
    ivc_pkg::t_rec   r_qry;
    logic [CW-1:0]   r_count, r_pos, r_chk_pos;
    logic            r_chk_v, r_found, r_walk;
    logic [DB-1:0]   r_ov;
    logic [GB-1:0]   r_gr;
    logic            r_ov_v, r_w_v;
    logic [PW-1:0]   r_w;
    logic [LW-1:0]   r_sum_len;
    logic [SW-1:0]   r_sum_w;
    logic [RW-1:0]   r_rem_a, r_rem_f, r_dsh;
    logic [FB-1:0]   r_qa, r_qf;
    logic            r_sat_a, r_sat_f, r_res_ok, r_zero;
    logic [STW-1:0]  r_step;
    logic            r_out_v;
    logic [ivc_pkg::OUT_DATA_BITS-1:0] r_out;

    logic            w_pop, w_end, w_hit, w_push, w_zero;
    logic [DB-1:0]   w_lo, w_hi, w_ov, w_seg;
    logic [PW-1:0]   w_prod;
    logic            w_ta, w_tf, w_slot;
    logic [GB-1:0]   w_avg;
    logic [FB:0]     w_frac;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_slot      = !r_out_v || i_m_tready;
    assign o_m_tvalid  = r_out_v;
    assign o_m_tdata   = r_out;

    // Table write on load and registered read at the walk pointer.
    always_ff @(posedge i_clk) begin
        if (w_pop && i_cmd.op == ivc_pkg::OP_LOAD && r_count < CW'(TABLE_DEPTH)) begin
            r_mem[r_count[AW-1:0]] <= i_cmd.rec;
        end
        r_rd <= r_mem[r_pos[AW-1:0]];
    end

    // Overlap of the record just read with the queried segment.
    always_comb begin
        w_end  = r_chk_pos >= r_count;
        w_hit  = r_rd.group_id == r_qry.group_id;
        w_lo   = (r_qry.depth_from > r_rd.depth_from) ? r_qry.depth_from : r_rd.depth_from;
        w_hi   = (r_qry.depth_to < r_rd.depth_to) ? r_qry.depth_to : r_rd.depth_to;
        w_ov   = (w_hi > w_lo) ? (w_hi - w_lo) : '0;
        w_push = (r_state == S_SCAN) && r_chk_v && !w_end && w_hit;
        w_zero = r_qry.depth_to <= r_qry.depth_from;
        w_seg  = r_qry.depth_to - r_qry.depth_from;
        w_prod = PW'(r_ov) * PW'(r_gr);
        w_ta   = r_rem_a >= r_dsh;
        w_tf   = r_rem_f >= r_dsh;
    end

    // Final result fields with saturation.
    always_comb begin
        w_avg  = '0;
        w_frac = '0;
        if (r_res_ok) begin
            w_avg  = r_sat_a ? {GB{1'b1}} : GB'(r_qa);
            w_frac = r_sat_f ? {1'b1, {FB{1'b0}}} : {1'b0, r_qf};
        end
    end

    // Multiply-accumulate pipeline: overlap, product, then sums.
    always_ff @(posedge i_clk) begin
        r_ov   <= w_ov;
        r_gr   <= r_rd.grade;
        r_w    <= w_prod;
        r_w_v  <= r_ov_v;
        if (r_state == S_IDLE) begin
            r_sum_len <= '0;
            r_sum_w   <= '0;
        end else begin
            if (r_ov_v) begin
                r_sum_len <= r_sum_len + LW'(r_ov);
            end
            if (r_w_v) begin
                r_sum_w <= r_sum_w + SW'(r_w);
            end
        end
    end

    // Divider datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DRAIN) begin
            r_sat_a <= r_sum_w >= SW'({w_seg, {FB{1'b0}}});
            r_sat_f <= r_sum_len >= LW'(w_seg);
            r_rem_a <= r_sum_w[RW-1:0];
            r_rem_f <= {r_sum_len[DB-1:0], {FB{1'b0}}};
            r_dsh   <= {1'b0, w_seg, {(FB-1){1'b0}}};
            r_qa    <= '0;
            r_qf    <= '0;
            r_step  <= '0;
            r_res_ok <= r_found && !w_zero;
            r_zero  <= w_zero;
        end else if (r_state == S_DIV) begin
            r_rem_a <= w_ta ? (r_rem_a - r_dsh) : r_rem_a;
            r_rem_f <= w_tf ? (r_rem_f - r_dsh) : r_rem_f;
            r_qa    <= {r_qa[FB-2:0], w_ta};
            r_qf    <= {r_qf[FB-2:0], w_tf};
            r_dsh   <= r_dsh >> 1;
            r_step  <= r_step + 1'b1;
        end
    end

    // Query latch and output payload.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_qry <= i_cmd.rec;
        end
        if (r_state == S_DONE && w_slot) begin
            r_out <= ivc_pkg::OUT_DATA_BITS'({r_zero, w_frac, w_avg, r_found});
        end
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pos     <= '0;
            r_chk_pos <= '0;
            r_chk_v   <= 1'b0;
            r_found   <= 1'b0;
            r_walk    <= 1'b0;
            r_ov_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_ov_v <= w_push;
            // A new result enters as the old one leaves or when the slot is empty.
            if (r_state == S_DONE && w_slot) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_m_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_pop) begin
                        unique case (i_cmd.op)
                            ivc_pkg::OP_LOAD: begin
                                if (r_count < CW'(TABLE_DEPTH)) begin
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            ivc_pkg::OP_CLEAR: r_count <= '0;
                            ivc_pkg::OP_QUERY: begin
                                r_pos   <= '0;
                                r_chk_v <= 1'b0;
                                r_found <= 1'b0;
                                r_walk  <= 1'b0;
                                r_state <= S_SCAN;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN: begin
                    // Issue the next read while checking the previous one.
                    r_pos     <= r_pos + 1'b1;
                    r_chk_pos <= r_pos;
                    r_chk_v   <= 1'b1;
                    if (r_chk_v) begin
                        if (w_end || (r_walk && !w_hit)) begin
                            r_state <= S_DRAIN;
                        end else if (w_hit) begin
                            r_walk  <= 1'b1;
                            r_found <= 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    // Sums are final once both pipeline stages are empty.
                    if (!r_ov_v && !r_w_v) begin
                        r_state <= (r_found && !w_zero) ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    if (r_step == STW'(FB - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_slot) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: design/interval_weighted_compositing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_weighted_compositing
// Length-weighted grade compositing of a query segment over a loaded
// table of sample intervals.
// ----------------------------------------------------------------------------
// Usage: the slave stream carries commands, the function code on s tuser
// (load record, query segment, clear table). Loads and clears give no
// output transaction; each query gives exactly one on the master stream.
// A front end queues up to two decoded commands so the sender is not held
// while the back end works. A query walks the table with one record read
// per cycle from the table memory, then drains the multiply-accumulate
// pipeline, runs the two dividers side by side when the group was found
// and the segment is not of zero length, and writes the result into the
// output register.
// Reset empties the queue, sets the record count to zero and drops any
// pending result; table contents are not cleared.
// When the receiver stalls, the result waits in the output register, the
// back end holds its next result, and the queue fills before the slave
// side stops accepting.
// ----------------------------------------------------------------------------
module interval_weighted_compositing #(
    parameter int TABLE_DEPTH = ivc_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // group_id[15:0], depth_from[39:16], depth_to[63:40], grade_in[79:64]
    input  logic [ivc_pkg::IN_DATA_BITS-1:0]    i_s_tdata,
    // func[1:0]
    input  logic [ivc_pkg::FUNC_BITS-1:0]       i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // group_found[0], avg_grade[16:1], covered_fraction[33:17],
    // zero_length[34], zero fill[39:35]
    output logic [ivc_pkg::OUT_DATA_BITS-1:0]   o_m_tdata
);

    ivc_pkg::t_cmd w_cmd;
    logic          w_cmd_valid, w_cmd_ready;

    // Command decode and queue.
    ivc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready),
        .o_cmd       (w_cmd)
    );

    // Table, walk, accumulation and division.
    ivc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule

FILE: design/ivc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ivc_checker
// Port-level checks of the compositing block, attached by bind.
// ----------------------------------------------------------------------------
module ivc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [ivc_pkg::OUT_DATA_BITS-1:0]   o_m_tdata
);

    // A pending result is held until the transaction completes.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result pending after reset");

    // A zero-length segment reports zero grade and zero coverage.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[34] |-> o_m_tdata[33:1] == 33'd0)
        else $error("zero-length segment with nonzero result");

    // A missing group reports zero grade and zero coverage.
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[33:1] == 33'd0)
        else $error("missing group with nonzero result");

    // Coverage never exceeds one.
    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[33] |-> o_m_tdata[32:17] == 16'd0)
        else $error("covered fraction above one");

endmodule

bind interval_weighted_compositing ivc_checker u_ivc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: dv/interval_weighted_compositing_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_weighted_compositing_test
// Self-checking bench: loads interval tables, runs segment queries and clears
// through the input stream, predicts each query result with a local model of
// the compositing math and compares it with the output stream.
// ----------------------------------------------------------------------------
module interval_weighted_compositing_test;

    localparam int TDEPTH = ivc_pkg::TABLE_DEPTH_DEF;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] gid;
        logic [23:0] dfrom;
        logic [23:0] dto;
        logic [15:0] grade;
    } t_item;

    typedef struct packed {
        logic        found;
        logic [15:0] avg;
        logic [16:0] frac;
        logic        zlen;
    } t_comp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [ivc_pkg::IN_DATA_BITS-1:0] i_s_tdata = '0;
    logic [ivc_pkg::FUNC_BITS-1:0] i_s_tuser = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [ivc_pkg::OUT_DATA_BITS-1:0] o_m_tdata;

    interval_weighted_compositing DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the record table.
    logic [15:0] tab_gid [TDEPTH];
    logic [23:0] tab_from [TDEPTH];
    logic [23:0] tab_to [TDEPTH];
    logic [15:0] tab_grade [TDEPTH];
    int unsigned tab_count = 0;

    t_item pending_items[$];
    t_comp expected_comps[$];
    int errors = 0;
    int n_queries = 0;
    int n_results = 0;
    bit stim_done = 1'b0;

    // Apply one accepted command to the local table and queue any result.
    task automatic apply_command(input t_item it);
        int unsigned pos;
        longint unsigned seg, ov, lo, hi, sum_len, sum_w, avg;
        t_comp c;
        begin
            pos = 0; sum_len = 0; sum_w = 0;
            c = '0;
            if (it.func == ivc_pkg::FUNC_LOAD) begin
                if (tab_count < TDEPTH) begin
                    tab_gid[tab_count] = it.gid;
                    tab_from[tab_count] = it.dfrom;
                    tab_to[tab_count] = it.dto;
                    tab_grade[tab_count] = it.grade;
                    tab_count++;
                end
            end else if (it.func == ivc_pkg::FUNC_CLEAR) begin
                tab_count = 0;
            end else if (it.func == ivc_pkg::FUNC_QUERY) begin
                c.zlen = (it.dto <= it.dfrom);
                while (pos < tab_count && tab_gid[pos] != it.gid) pos++;
                c.found = (pos < tab_count);
                if (c.found && !c.zlen) begin
                    seg = it.dto - it.dfrom;
                    while (pos < tab_count && tab_gid[pos] == it.gid) begin
                        lo = (it.dfrom > tab_from[pos]) ? it.dfrom : tab_from[pos];
                        hi = (it.dto < tab_to[pos]) ? it.dto : tab_to[pos];
                        ov = (hi > lo) ? hi - lo : 0;
                        sum_len += ov;
                        sum_w += ov * tab_grade[pos];
                        pos++;
                    end
                    avg = sum_w / seg;
                    c.avg = (avg > 65535) ? 16'hFFFF : avg[15:0];
                    c.frac = (sum_len >= seg) ? 17'h10000 : 17'((sum_len << 16) / seg);
                end
                expected_comps.push_back(c);
                n_queries++;
            end
        end
    endtask

    // Handshakes seen at the last rising edge.
    logic o_s_tready_q = 1'b0;
    logic o_m_acc_q = 1'b0;

    // Driver: a randomly drawn wait after each accepted item on either side.
    int src_gap = 0;
    int snk_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready_q) begin
                void'(pending_items.pop_front());
                src_gap = $urandom_range(0, 3);
            end
            if (src_gap > 0) begin
                i_s_tvalid <= 1'b0;
                src_gap--;
            end else if (pending_items.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata <= {pending_items[0].grade, pending_items[0].dto,
                              pending_items[0].dfrom, pending_items[0].gid};
                i_s_tuser <= pending_items[0].func;
            end else begin
                i_s_tvalid <= 1'b0;
            end
            if (o_m_acc_q) begin
                snk_gap = $urandom_range(0, 3);
            end
            if (snk_gap > 0) begin
                i_m_tready <= 1'b0;
                snk_gap--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance.
    always @(posedge i_clk) begin
        t_comp got, exp_c;
        o_s_tready_q <= i_rst_n && i_s_tvalid && o_s_tready;
        o_m_acc_q <= i_rst_n && o_m_tvalid && i_m_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                apply_command(t_item'({i_s_tuser, i_s_tdata[15:0], i_s_tdata[39:16],
                                       i_s_tdata[63:40], i_s_tdata[79:64]}));
            if (o_m_tvalid && i_m_tready) begin
                got.found = o_m_tdata[0];
                got.avg = o_m_tdata[16:1];
                got.frac = o_m_tdata[33:17];
                got.zlen = o_m_tdata[34];
                n_results++;
                if (expected_comps.size() == 0) begin
                    $error("unexpected result %h", o_m_tdata);
                    errors++;
                end else begin
                    exp_c = expected_comps.pop_front();
                    if (got.found !== exp_c.found) begin
                        $error("group_found exp %0d got %0d", exp_c.found, got.found);
                        errors++;
                    end
                    if (got.avg !== exp_c.avg) begin
                        $error("avg_grade exp %0d got %0d", exp_c.avg, got.avg);
                        errors++;
                    end
                    if (got.frac !== exp_c.frac) begin
                        $error("covered_fraction exp %0d got %0d", exp_c.frac, got.frac);
                        errors++;
                    end
                    if (got.zlen !== exp_c.zlen) begin
                        $error("zero_length exp %0d got %0d", exp_c.zlen, got.zlen);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic t_item mk(input logic [1:0] f, input logic [15:0] g,
                                 input logic [23:0] a, input logic [23:0] b,
                                 input logic [15:0] gr);
        t_item it;
        begin
            it.func = f; it.gid = g; it.dfrom = a; it.dto = b; it.grade = gr;
            return it;
        end
    endfunction

    // Random depth: mostly a small window, sometimes the full range.
    function automatic logic [23:0] rdepth();
        return ($urandom_range(0, 7) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000));
    endfunction

    initial begin
        int n, g, len;
        logic [23:0] a;
        // Directed: extremes, touching boundaries, inverted record, zero length.
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'd5, 24'd0, 24'd10, 16'd0));
        pending_items.push_back(mk(ivc_pkg::FUNC_LOAD, 16'hFFFF, 24'd0, 24'hFFFFFF,
                                   16'hFFFF));
        pending_items.push_back(mk(ivc_pkg::FUNC_LOAD, 16'd0, 24'd100, 24'd200, 16'd1000));
        pending_items.push_back(mk(ivc_pkg::FUNC_LOAD, 16'd0, 24'd200, 24'd300, 16'd3000));
        pending_items.push_back(mk(ivc_pkg::FUNC_LOAD, 16'd0, 24'd400, 24'd350, 16'd500));
        pending_items.push_back(mk(ivc_pkg::FUNC_LOAD, 16'd7, 24'd0, 24'd50, 16'd9));
        pending_items.push_back(mk(ivc_pkg::FUNC_LOAD, 16'd0, 24'd0, 24'd999, 16'd1));
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'hFFFF, 24'd0, 24'hFFFFFF, 16'd0));
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'hFFFF, 24'd5, 24'd6, 16'hFFFF));
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'd0, 24'd100, 24'd300, 16'd0));
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'd0, 24'd200, 24'd200, 16'd0));
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'd0, 24'd300, 24'd100, 16'd0));
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'd0, 24'd0, 24'd1000, 16'd0));
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'd7, 24'd0, 24'd50, 16'd0));
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'd9, 24'd0, 24'd50, 16'd0));
        pending_items.push_back(mk(2'd3, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF));
        pending_items.push_back(mk(ivc_pkg::FUNC_CLEAR, 16'd0, 24'd0, 24'd0, 16'd0));
        pending_items.push_back(mk(ivc_pkg::FUNC_QUERY, 16'd0, 24'd100, 24'd300, 16'd0));
        // Random phases: small tables of a few groups, then queries.
        n = 18;
        while (n < 550) begin
            for (int r = $urandom_range(1, 12); r > 0; r--) begin
                g = $urandom_range(0, 3);
                a = rdepth();
                len = $urandom_range(0, 9) == 0 ? -5 : $urandom_range(0, 600);
                pending_items.push_back(mk(ivc_pkg::FUNC_LOAD, 16'(g), a, 24'(a + len),
                                           16'($urandom)));
                n++;
            end
            for (int q = $urandom_range(1, 8); q > 0; q--) begin
                a = rdepth();
                len = $urandom_range(0, 9) == 0 ? -$urandom_range(0, 3)
                                                : $urandom_range(1, 1500);
                pending_items.push_back(mk(($urandom_range(0, 30) == 0) ? 2'd3
                                                                        : ivc_pkg::FUNC_QUERY,
                                           ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                                       : 16'($urandom_range(0, 4)),
                                           a, 24'(a + len), 16'($urandom)));
                n++;
            end
            if ($urandom_range(0, 2) == 0) begin
                pending_items.push_back(mk(ivc_pkg::FUNC_CLEAR, 16'($urandom), 24'($urandom),
                                           24'($urandom), 16'($urandom)));
                n++;
            end
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !i_s_tvalid);
        wait (expected_comps.size() == 0);
        repeat (TDEPTH + 40) @(posedge i_clk);
        $display("Covered %0d queries with %0d results checked, table fill and clear.",
                 n_queries, n_results);
        if (errors == 0 && expected_comps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
